/* hw/rtl/crc32c_cobs_frame_encoder_macros.svh */
// Assertion macros shared by the frame encoder.
`ifndef CRC32C_COBS_FRAME_ENCODER_MACROS_SVH
`define CRC32C_COBS_FRAME_ENCODER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CCFE_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CCFE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ccfe_pkg.sv */
`default_nettype none
package ccfe_pkg;

  localparam int FRAME_MEMORY_BYTES = 4096;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [7:0] CODE_FULL = 8'hFF;

  localparam logic [1:0] CFG_FRAME_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_MIN_MESSAGE_LEN = 2'd1;
  localparam logic [1:0] CFG_MAX_MESSAGE_LEN = 2'd2;

  localparam logic [12:0] RST_FRAME_CAPACITY = 13'd4096;
  localparam logic [12:0] RST_MIN_MESSAGE_LEN = 13'd8;
  localparam logic [12:0] RST_MAX_MESSAGE_LEN = 13'd1024;

  localparam int ERR_OVF = 0;
  localparam int ERR_LEN = 1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last_byte;
  } in_t;

  typedef struct packed {
    logic        write_enable;
    logic [11:0] write_address;
    logic [7:0]  write_data;
    logic        frame_done;
    logic [1:0]  frame_status;
    logic [12:0] frame_length;
  } out_t;

  // One octet for the encoder, with the sticky length error and a flag that
  // closes the frame after this octet.
  typedef struct packed {
    logic [7:0] octet;
    logic       len_err;
    logic       fin;
  } op_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] octet);
    logic [31:0] c;
    c = crc ^ {24'd0, octet};
    for (int b = 0; b < 8; b++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/crc32c_cobs_frame_encoder.sv */
`default_nettype none
// COBS frame encoder with a CRC-32C trailer. Message bytes enter one word at a time; each
// result word is one write to an external frame memory, with code bytes written back to
// their reserved slots, and the final word of a frame carries frame_done, the status and the
// encoded length (zero on error, where a single status-only word closes the frame). The front
// end takes one input word per cycle, unless stalled, into a four-entry queue and updates the
// CRC as it goes; a last byte stalls the input while it queues the four CRC bytes. The back
// end retires one queued octet per cycle, writing at most one byte, unless the output stalls;
// an octet that fills a code block takes a PH_FULL step for its code byte, and a frame closes
// in PH_FIN, then PH_DELIM unless it failed; ordinary bytes sustain one word per cycle.
module crc32c_cobs_frame_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  ccfe_pkg::in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output ccfe_pkg::out_t   out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);
  import ccfe_pkg::*;

  logic [12:0] frame_capacity;
  logic [12:0] min_message_len;
  logic [12:0] max_message_len;
  logic [12:0] cap;

  logic q_full;
  logic q_push;
  op_t  q_op;
  logic q_pop;
  logic head_valid;
  op_t  head_op;

  assign cfg_ready = 1'b1;
  assign cap = (frame_capacity > 13'(FRAME_MEMORY_BYTES)) ? 13'(FRAME_MEMORY_BYTES)
                                                          : frame_capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_capacity <= RST_FRAME_CAPACITY;
      min_message_len <= RST_MIN_MESSAGE_LEN;
      max_message_len <= RST_MAX_MESSAGE_LEN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_CAPACITY: frame_capacity <= cfg_data;
        CFG_MIN_MESSAGE_LEN: min_message_len <= cfg_data;
        CFG_MAX_MESSAGE_LEN: max_message_len <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ccfe_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .min_message_len (min_message_len),
    .max_message_len (max_message_len),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_op            (q_op)
  );

  ccfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_op    (q_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  ccfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cap        (cap),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

`include "crc32c_cobs_frame_encoder_macros.svh"

  `CCFE_ASSERT_SAME(a_write_below_cap, clk, rst, out_valid && out_data.write_enable, {1'b0, out_data.write_address} < cap, "frame write at or beyond capacity")
  `CCFE_ASSERT_SAME(a_error_word_empty, clk, rst, out_valid && out_data.frame_done && out_data.frame_status != STATUS_OK, !out_data.write_enable && out_data.frame_length == 13'd0, "failed frame carries a write or a length")
  `CCFE_ASSERT_NEXT(a_last_holds_input, clk, rst, in_valid && !in_stall && in_data.is_last_byte, in_stall, "input taken while trailer bytes are queued")

endmodule
`default_nettype wire

/* hw/rtl/ccfe_front.sv */
`default_nettype none
module ccfe_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  ccfe_pkg::in_t     in_data,
  input  wire logic [12:0]  min_message_len,
  input  wire logic [12:0]  max_message_len,
  input  wire logic         q_full,
  output logic              q_push,
  output ccfe_pkg::op_t     q_op
);
  import ccfe_pkg::*;

  logic [12:0] msg_cnt;
  logic [31:0] crc;
  logic        len_err;
  logic        crc_busy;
  logic [1:0]  crc_k;
  logic [31:0] crc_fin;

  logic        accept;
  logic [12:0] msg_cnt_next;
  logic [31:0] crc_next;
  logic        len_err_next;

  assign in_stall = crc_busy | q_full;
  assign accept = in_valid & ~in_stall;

  always_comb begin
    msg_cnt_next = (msg_cnt == 13'h1FFF) ? msg_cnt : 13'(msg_cnt + 13'd1);
    crc_next = crc_byte(crc, in_data.data_byte);
    len_err_next = len_err | (msg_cnt_next > max_message_len) |
                   (in_data.is_last_byte & (msg_cnt_next < min_message_len));
  end

  always_comb begin
    q_push = 1'b0;
    q_op = '0;
    if (accept) begin
      q_push = 1'b1;
      q_op.octet = in_data.data_byte;
      q_op.len_err = len_err_next;
    end else if (crc_busy && !q_full) begin
      q_push = 1'b1;
      q_op.octet = crc_fin[7:0];
      q_op.fin = (crc_k == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_cnt <= '0;
      crc <= CRC_INIT;
      len_err <= 1'b0;
      crc_busy <= 1'b0;
      crc_k <= '0;
    end else if (accept) begin
      if (in_data.is_last_byte) begin
        msg_cnt <= '0;
        crc <= CRC_INIT;
        len_err <= 1'b0;
        crc_busy <= 1'b1;
        crc_k <= '0;
        crc_fin <= ~crc_next;
      end else begin
        msg_cnt <= msg_cnt_next;
        crc <= crc_next;
        len_err <= len_err_next;
      end
    end else if (crc_busy && !q_full) begin
      crc_fin <= crc_fin >> 8;
      crc_k <= 2'(crc_k + 2'd1);
      if (crc_k == 2'd3) begin
        crc_busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ccfe_queue.sv */
`default_nettype none
module ccfe_queue (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  ccfe_pkg::op_t  push_op,
  output logic           full,
  input  wire logic      pop,
  output logic           head_valid,
  output ccfe_pkg::op_t  head_op
);
  import ccfe_pkg::*;

  op_t                  slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full = (count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QUEUE_PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= QUEUE_PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= (QUEUE_PTR_W + 1)'(count + 1'b1);
      end else if (pop && !push) begin
        count <= (QUEUE_PTR_W + 1)'(count - 1'b1);
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ccfe_back.sv */
`default_nettype none
module ccfe_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [12:0]  cap,
  input  wire logic         head_valid,
  input  ccfe_pkg::op_t     head_op,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output ccfe_pkg::out_t    out_data
);
  import ccfe_pkg::*;

  localparam logic [1:0] PH_ENC = 2'd0;
  localparam logic [1:0] PH_FULL = 2'd1;
  localparam logic [1:0] PH_FIN = 2'd2;
  localparam logic [1:0] PH_DELIM = 2'd3;

  logic [1:0]  phase;
  logic [12:0] wp;
  logic [11:0] code_addr;
  logic [7:0]  code_cnt;
  logic [1:0]  err;

  logic [1:0]  phase_next;
  logic [12:0] wp_next;
  logic [11:0] code_addr_next;
  logic [7:0]  code_cnt_next;
  logic [1:0]  err_next;
  logic        emit;
  out_t        res;
  logic        step;
  logic        retire;
  logic [1:0]  err_a;
  logic [1:0]  err_f;
  logic        at_cap;
  logic [7:0]  cnt_inc;

  function automatic out_t mk_write(input logic [11:0] addr, input logic [7:0] data);
    out_t r;
    r = '0;
    r.write_enable = 1'b1;
    r.write_address = addr;
    r.write_data = data;
    return r;
  endfunction

  assign step = head_valid & (~out_valid | ~out_stall);
  assign at_cap = (wp >= cap);
  assign cnt_inc = 8'(code_cnt + 8'd1);
  assign err_a = err | {head_op.len_err, 1'b0};

  always_comb begin
    phase_next = phase;
    wp_next = wp;
    code_addr_next = code_addr;
    code_cnt_next = code_cnt;
    err_next = err;
    emit = 1'b0;
    res = '0;
    retire = 1'b0;
    err_f = err;
    case (phase)
      PH_ENC: begin
        err_next = err_a;
        retire = 1'b1;
        if (err_a != '0) begin
        end else if (at_cap) begin
          err_next[ERR_OVF] = 1'b1;
        end else if (head_op.octet == 8'd0) begin
          emit = 1'b1;
          res = mk_write(code_addr, code_cnt);
          code_addr_next = wp[11:0];
          wp_next = 13'(wp + 13'd1);
          code_cnt_next = 8'd1;
        end else begin
          emit = 1'b1;
          res = mk_write(wp[11:0], head_op.octet);
          wp_next = 13'(wp + 13'd1);
          code_cnt_next = cnt_inc;
          if (cnt_inc == CODE_FULL) begin
            retire = 1'b0;
            phase_next = PH_FULL;
          end
        end
      end
      PH_FULL: begin
        retire = 1'b1;
        phase_next = PH_ENC;
        if (at_cap) begin
          err_next[ERR_OVF] = 1'b1;
        end else begin
          emit = 1'b1;
          res = mk_write(code_addr, CODE_FULL);
          code_addr_next = wp[11:0];
          wp_next = 13'(wp + 13'd1);
          code_cnt_next = 8'd1;
        end
      end
      PH_FIN: begin
        if (err == '0 && at_cap) begin
          err_f[ERR_OVF] = 1'b1;
        end
        if (err_f != '0) begin
          emit = 1'b1;
          res = '0;
          res.frame_done = 1'b1;
          res.frame_status = err_f[ERR_LEN] ? STATUS_BAD_LENGTH : STATUS_OVERFLOW;
          phase_next = PH_ENC;
        end else begin
          emit = 1'b1;
          res = mk_write(code_addr, code_cnt);
          phase_next = PH_DELIM;
        end
      end
      PH_DELIM: begin
        emit = 1'b1;
        res = mk_write(wp[11:0], 8'd0);
        res.frame_done = 1'b1;
        res.frame_status = STATUS_OK;
        res.frame_length = 13'(wp + 13'd1);
        phase_next = PH_ENC;
      end
      default: begin
        phase_next = PH_ENC;
      end
    endcase
    if (retire && head_op.fin) begin
      retire = 1'b0;
      phase_next = PH_FIN;
    end
    if (phase == PH_DELIM || (phase == PH_FIN && err_f != '0)) begin
      retire = 1'b1;
      wp_next = 13'd1;
      code_addr_next = '0;
      code_cnt_next = 8'd1;
      err_next = '0;
    end
  end

  assign pop = step & retire;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_ENC;
      wp <= 13'd1;
      code_addr <= '0;
      code_cnt <= 8'd1;
      err <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        phase <= phase_next;
        wp <= wp_next;
        code_addr <= code_addr_next;
        code_cnt <= code_cnt_next;
        err <= err_next;
      end
      if (step && emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import ccfe_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_e;
  typedef enum logic [1:0] {MIX_ANY, MIX_SPARSE, MIX_NONZERO, MIX_EDGES} byte_mix_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_index;
    logic [12:0] reg_value;
    logic [7:0]  octet;
    logic        last;
    logic        typed;
    logic [1:0]  status;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [26] = '{
    '{ROW_BYTE, 2'd0, 13'd0, 8'h00, 1'b1, 1'b1, STATUS_BAD_LENGTH},
    '{ROW_BYTE, 2'd0, 13'd0, 8'h00, 1'b0, 1'b0, STATUS_OK},
    '{ROW_BYTE, 2'd0, 13'd0, 8'hFF, 1'b0, 1'b0, STATUS_OK},
    '{ROW_BYTE, 2'd0, 13'd0, 8'h01, 1'b0, 1'b0, STATUS_OK},
    '{ROW_BYTE, 2'd0, 13'd0, 8'h80, 1'b0, 1'b0, STATUS_OK},
    '{ROW_BYTE, 2'd0, 13'd0, 8'h7F, 1'b0, 1'b0, STATUS_OK},
    '{ROW_BYTE, 2'd0, 13'd0, 8'h00, 1'b0, 1'b0, STATUS_OK},
    '{ROW_BYTE, 2'd0, 13'd0, 8'h00, 1'b0, 1'b0, STATUS_OK},
    '{ROW_BYTE, 2'd0, 13'd0, 8'hAA, 1'b0, 1'b0, STATUS_OK},
    '{ROW_BYTE, 2'd0, 13'd0, 8'h55, 1'b1, 1'b0, STATUS_OK},
    '{ROW_CFG, CFG_MIN_MESSAGE_LEN, 13'd1, 8'h00, 1'b0, 1'b0, STATUS_OK},
    '{ROW_CFG, CFG_FRAME_CAPACITY, 13'd0, 8'h00, 1'b0, 1'b0, STATUS_OK},
    '{ROW_BYTE, 2'd0, 13'd0, 8'h12, 1'b1, 1'b1, STATUS_OVERFLOW},
    '{ROW_CFG, CFG_FRAME_CAPACITY, 13'd8191, 8'h00, 1'b0, 1'b0, STATUS_OK},
    '{ROW_CFG, CFG_MAX_MESSAGE_LEN, 13'd1, 8'h00, 1'b0, 1'b0, STATUS_OK},
    '{ROW_BYTE, 2'd0, 13'd0, 8'h00, 1'b0, 1'b0, STATUS_OK},
    '{ROW_BYTE, 2'd0, 13'd0, 8'h00, 1'b1, 1'b1, STATUS_BAD_LENGTH},
    '{ROW_CFG, CFG_MAX_MESSAGE_LEN, 13'd4096, 8'h00, 1'b0, 1'b0, STATUS_OK},
    '{ROW_CFG, CFG_MIN_MESSAGE_LEN, 13'd4096, 8'h00, 1'b0, 1'b0, STATUS_OK},
    '{ROW_BYTE, 2'd0, 13'd0, 8'hFF, 1'b1, 1'b1, STATUS_BAD_LENGTH},
    '{ROW_CFG, CFG_MIN_MESSAGE_LEN, 13'd0, 8'h00, 1'b0, 1'b0, STATUS_OK},
    '{ROW_BYTE, 2'd0, 13'd0, 8'hFF, 1'b1, 1'b0, STATUS_OK},
    '{ROW_CFG, CFG_FRAME_CAPACITY, 13'd4, 8'h00, 1'b0, 1'b0, STATUS_OK},
    '{ROW_BYTE, 2'd0, 13'd0, 8'h01, 1'b1, 1'b0, STATUS_OK},
    '{ROW_CFG, CFG_UNUSED, 13'd0, 8'h00, 1'b0, 1'b0, STATUS_OK},
    '{ROW_CFG, CFG_FRAME_CAPACITY, 13'd4096, 8'h00, 1'b0, 1'b0, STATUS_OK}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  logic [12:0] cap_reg = RST_FRAME_CAPACITY;
  logic [12:0] min_len_reg = RST_MIN_MESSAGE_LEN;
  logic [12:0] max_len_reg = RST_MAX_MESSAGE_LEN;

  logic [31:0] crc_acc = CRC_INIT;
  logic [12:0] wr_ptr = 13'd1;
  logic [12:0] code_slot = 13'd0;
  logic [7:0]  code_run = 8'd1;
  logic [12:0] byte_count = 13'd0;
  logic [1:0]  frame_err = 2'd0;

  out_t pending_writes[$];
  int   mismatches = 0;
  bit   src_idle = 1'b1;
  bit   sink_idle = 1'b1;
  int   stall_left = 0;

  crc32c_cobs_frame_encoder i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

  function automatic logic [31:0] crc32c_fold(input logic [31:0] acc, input logic [7:0] octet);
    logic [31:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ octet[i];
      r = {1'b0, r[31:1]} ^ (fb ? CRC_POLY : 32'd0);
    end
    return r;
  endfunction

  function automatic out_t frame_word(input logic we, input logic [11:0] addr,
                                      input logic [7:0] data, input logic done,
                                      input logic [1:0] status, input logic [12:0] len);
    out_t w;
    w.write_enable = we;
    w.write_address = addr;
    w.write_data = data;
    w.frame_done = done;
    w.frame_status = status;
    w.frame_length = len;
    return w;
  endfunction

  function automatic logic [12:0] usable_capacity();
    return (cap_reg > FRAME_MEMORY_BYTES) ? 13'(FRAME_MEMORY_BYTES) : cap_reg;
  endfunction

  task automatic stuff_octet(input logic [7:0] octet);
    if (frame_err != 2'd0) return;
    if (wr_ptr >= usable_capacity()) begin
      frame_err[ERR_OVF] = 1'b1;
      return;
    end
    if (octet == 8'd0) begin
      pending_writes.push_back(frame_word(1'b1, code_slot[11:0], code_run, 1'b0, STATUS_OK, 13'd0));
      code_slot = wr_ptr;
      wr_ptr++;
      code_run = 8'd1;
      return;
    end
    pending_writes.push_back(frame_word(1'b1, wr_ptr[11:0], octet, 1'b0, STATUS_OK, 13'd0));
    wr_ptr++;
    code_run++;
    if (code_run == CODE_FULL) begin
      if (wr_ptr >= usable_capacity()) begin
        frame_err[ERR_OVF] = 1'b1;
        return;
      end
      pending_writes.push_back(frame_word(1'b1, code_slot[11:0], code_run, 1'b0, STATUS_OK, 13'd0));
      code_slot = wr_ptr;
      wr_ptr++;
      code_run = 8'd1;
    end
  endtask

  task automatic encode_message_byte(input logic [7:0] octet, input logic last);
    logic [31:0] trailer;
    if (byte_count != 13'h1FFF) byte_count++;
    crc_acc = crc32c_fold(crc_acc, octet);
    if (byte_count > max_len_reg) frame_err[ERR_LEN] = 1'b1;
    if (last && byte_count < min_len_reg) frame_err[ERR_LEN] = 1'b1;
    stuff_octet(octet);
    if (!last) return;
    trailer = ~crc_acc;
    for (int k = 0; k < 4; k++) stuff_octet(trailer[8*k +: 8]);
    if (frame_err == 2'd0 && wr_ptr >= usable_capacity()) frame_err[ERR_OVF] = 1'b1;
    if (frame_err == 2'd0) begin
      pending_writes.push_back(frame_word(1'b1, code_slot[11:0], code_run, 1'b0, STATUS_OK, 13'd0));
      pending_writes.push_back(frame_word(1'b1, wr_ptr[11:0], 8'd0, 1'b1, STATUS_OK, wr_ptr + 13'd1));
    end else begin
      pending_writes.push_back(frame_word(1'b0, 12'd0, 8'd0, 1'b1,
        frame_err[ERR_LEN] ? STATUS_BAD_LENGTH : STATUS_OVERFLOW, 13'd0));
    end
    crc_acc = CRC_INIT;
    wr_ptr = 13'd1;
    code_slot = 13'd0;
    code_run = 8'd1;
    byte_count = 13'd0;
    frame_err = 2'd0;
  endtask

  task automatic flag_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [12:0] got, input logic [12:0] want);
    if (got !== want) flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic check_write(input out_t got);
    out_t want;
    if (pending_writes.size() == 0) begin
      flag_mismatch($sformatf("word %h arrived with nothing expected", got));
      return;
    end
    want = pending_writes.pop_front();
    compare_field("write_enable", 13'(got.write_enable), 13'(want.write_enable));
    compare_field("write_address", 13'(got.write_address), 13'(want.write_address));
    compare_field("write_data", 13'(got.write_data), 13'(want.write_data));
    compare_field("frame_done", 13'(got.frame_done), 13'(want.frame_done));
    compare_field("frame_status", 13'(got.frame_status), 13'(want.frame_status));
    compare_field("frame_length", got.frame_length, want.frame_length);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) check_write(out_data);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_register(input logic [1:0] idx, input logic [12:0] value);
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_FRAME_CAPACITY: cap_reg = value;
      CFG_MIN_MESSAGE_LEN: min_len_reg = value;
      CFG_MAX_MESSAGE_LEN: max_len_reg = value;
      default: ;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] octet, input logic last,
                           input logic typed, input logic [1:0] status);
    int queued;
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_data <= {octet, last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    queued = pending_writes.size();
    encode_message_byte(octet, last);
    // A typed row replaces the predicted words with its single closing word.
    if (typed) begin
      while (pending_writes.size() > queued) pending_writes.delete(pending_writes.size() - 1);
      pending_writes.push_back(frame_word(1'b0, 12'd0, 8'd0, 1'b1, status, 13'd0));
    end
  endtask

  function automatic logic [7:0] pick_byte(input byte_mix_e mix);
    case (mix)
      MIX_SPARSE: return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      MIX_NONZERO: return 8'($urandom_range(1, 255));
      MIX_EDGES: begin
        case ($urandom_range(0, 5))
          0: return 8'h00;
          1: return 8'h01;
          2: return 8'h7F;
          3: return 8'h80;
          4: return 8'hFE;
          default: return 8'hFF;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input int len, input byte_mix_e mix);
    for (int i = 0; i < len; i++) push_byte(pick_byte(mix), i == len - 1, 1'b0, STATUS_OK);
  endtask

  initial begin
    int sent;
    int len;
    int spin;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
        write_register(DIRECTED_ROWS[r].reg_index, DIRECTED_ROWS[r].reg_value);
      end else begin
        push_byte(DIRECTED_ROWS[r].octet, DIRECTED_ROWS[r].last,
                  DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].status);
      end
    end

    sent = 0;
    while (sent < 24) begin
      src_idle = $urandom_range(0, 2) != 0;
      sink_idle = $urandom_range(0, 2) != 0;
      write_register(CFG_FRAME_CAPACITY, ($urandom_range(0, 2) == 0) ?
                     13'($urandom_range(0, 48)) : 13'($urandom_range(300, 8191)));
      write_register(CFG_MIN_MESSAGE_LEN, ($urandom_range(0, 3) == 0) ?
                     13'($urandom_range(9, 40)) : 13'($urandom_range(0, 8)));
      write_register(CFG_MAX_MESSAGE_LEN, ($urandom_range(0, 3) == 0) ?
                     13'($urandom_range(1, 12)) : 13'($urandom_range(24, 4096)));
      repeat ($urandom_range(1, 3)) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        send_frame(len, byte_mix_e'($urandom_range(0, 3)));
        sent += len;
      end
    end

    // A long run of nonzero bytes fills a whole code block.
    src_idle = 1'b0;
    sink_idle = 1'b0;
    write_register(CFG_FRAME_CAPACITY, 13'd4096);
    write_register(CFG_MIN_MESSAGE_LEN, 13'd1);
    write_register(CFG_MAX_MESSAGE_LEN, 13'd4096);
    send_frame($urandom_range(254, 256), MIX_NONZERO);
    in_valid <= 1'b0;

    spin = 0;
    while (pending_writes.size() != 0 && spin < 200000) begin
      @(posedge clk);
      spin++;
    end
    repeat (40) @(posedge clk);
    if (pending_writes.size() != 0) begin
      flag_mismatch($sformatf("%0d expected words never arrived", pending_writes.size()));
    end
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* crc32c_cobs_frame_encoder.f */
+incdir+hw/rtl
hw/rtl/ccfe_pkg.sv
hw/rtl/ccfe_front.sv
hw/rtl/ccfe_queue.sv
hw/rtl/ccfe_back.sv
hw/rtl/crc32c_cobs_frame_encoder.sv
tb/sv/tb_top.sv
